// File: hdl/prs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types, codes, reset values and helpers for the position report
// scheduler.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHEME        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNS_INTERVAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EMG_INTERVAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_DISTANCE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNS_DISTANCE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EMG_DISTANCE  = 3'd7;

    localparam logic [1:0] POL_TIMED    = 2'd0;
    localparam logic [1:0] POL_DISTANCE = 2'd1;
    localparam logic [1:0] POL_BOTH     = 2'd2;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_TRACK = 1'b1;

    localparam logic [31:0] RST_DEF_INTERVAL = 32'd30;
    localparam logic [31:0] RST_UNS_INTERVAL = 32'd30;
    localparam logic [31:0] RST_EMG_INTERVAL = 32'd10;
    localparam logic [31:0] RST_DEF_DISTANCE = 32'd1000;
    localparam logic [31:0] RST_UNS_DISTANCE = 32'd1000;
    localparam logic [31:0] RST_EMG_DISTANCE = 32'd100;
    localparam logic [31:0] RST_COUNTDOWN    = 32'd1;

    // reciprocal of 100 scaled by 2^37, exact for every 32-bit dividend
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
    localparam int unsigned DIV100_SHIFT = 37;

    typedef struct packed {
        logic        op;
        logic        sos_active;
        logic        card_present;
        logic [31:0] odometer;
        logic [15:0] track_interval;
        logic [31:0] track_validity;
    } prs_in_t;

    typedef struct packed {
        logic [1:0]  report_count;
        logic [31:0] odometer_out;
        logic        tracking_on;
    } prs_out_t;

    // x * 100 mod 2^32 as shifts and adds
    function automatic logic [31:0] mul100(input logic [31:0] x);
        return (x << 6) + (x << 5) + (x << 2);
    endfunction

    function automatic logic [31:0] div100(input logic [31:0] x);
        logic [63:0] prod;
        prod = {32'd0, x} * {32'd0, DIV100_MAGIC};
        return {5'd0, prod[63:DIV100_SHIFT]};
    endfunction

endpackage

// File: hdl/position_report_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_report_scheduler_unit
// Per-tick position report decision: tracking, timed and distance rules.
// ----------------------------------------------------------------------------
//  channel  | signals                       | direction | payload
//  ---------+-------------------------------+-----------+-----------------
//  req      | req_valid / req_ready         | in        | prs_in_t
//  rsp      | rsp_valid / rsp_ready         | out       | prs_out_t
//  cfg      | cfg_we, cfg_index, cfg_data   | in        | 32-bit register
//
//  one item per cycle while the receiver takes results; an item is taken into
//  the input register, then its result is offered from the result register,
//  where it waits until the receiver takes it
//  the mileage base update (times 100, add, reciprocal multiply) sets the
//  cycle time, since the next item depends on it
//  reset clears the valid flags and scheduler state and loads the register
//  defaults; no clearing pass; a stalled result holds and the input register keeps taking one more item
// ----------------------------------------------------------------------------
module position_report_scheduler_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  prs_pkg::prs_in_t                req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output prs_pkg::prs_out_t               rsp,
    input  logic                            cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);

    logic [1:0]        policy_reg;
    logic              scheme_reg;
    logic [31:0]       def_interval_reg;
    logic [31:0]       uns_interval_reg;
    logic [31:0]       emg_interval_reg;
    logic [31:0]       def_distance_reg;
    logic [31:0]       uns_distance_reg;
    logic [31:0]       emg_distance_reg;

    logic              in_valid_reg;
    prs_pkg::prs_in_t  in_reg;
    logic              out_valid_reg;
    prs_pkg::prs_out_t out_reg;

    logic [31:0]       countdown_reg;
    logic [31:0]       countdown_next;
    logic [31:0]       base_reg;
    logic [31:0]       base_next;
    logic [15:0]       track_int_reg;
    logic [15:0]       track_int_next;
    logic [31:0]       track_rem_reg;
    logic [31:0]       track_rem_next;
    logic              track_flag_reg;
    logic              track_flag_next;
    prs_pkg::prs_out_t out_next;

    logic              advance;
    logic [31:0]       cd_dec;
    logic [31:0]       rem_dec;
    logic              no_card_mode;
    logic [31:0]       sel_interval;
    logic [31:0]       sel_distance;
    logic [31:0]       moved;
    logic              dist_hit;
    logic [31:0]       snapped;
    logic              timed_take;
    logic              dist_take;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg       <= prs_pkg::POL_TIMED;
            scheme_reg       <= 1'b0;
            def_interval_reg <= prs_pkg::RST_DEF_INTERVAL;
            uns_interval_reg <= prs_pkg::RST_UNS_INTERVAL;
            emg_interval_reg <= prs_pkg::RST_EMG_INTERVAL;
            def_distance_reg <= prs_pkg::RST_DEF_DISTANCE;
            uns_distance_reg <= prs_pkg::RST_UNS_DISTANCE;
            emg_distance_reg <= prs_pkg::RST_EMG_DISTANCE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                prs_pkg::CFG_POLICY:       policy_reg       <= cfg_data[1:0];
                prs_pkg::CFG_SCHEME:       scheme_reg       <= cfg_data[0];
                prs_pkg::CFG_DEF_INTERVAL: def_interval_reg <= cfg_data;
                prs_pkg::CFG_UNS_INTERVAL: uns_interval_reg <= cfg_data;
                prs_pkg::CFG_EMG_INTERVAL: emg_interval_reg <= cfg_data;
                prs_pkg::CFG_DEF_DISTANCE: def_distance_reg <= cfg_data;
                prs_pkg::CFG_UNS_DISTANCE: uns_distance_reg <= cfg_data;
                prs_pkg::CFG_EMG_DISTANCE: emg_distance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_reg <= req;
        end
    end

    // rule evaluation
    always_comb
    begin
        cd_dec       = countdown_reg - 32'd1;
        rem_dec      = track_rem_reg - 32'd1;
        no_card_mode = scheme_reg && !in_reg.card_present;

        if (in_reg.sos_active)
        begin
            sel_interval = emg_interval_reg;
            sel_distance = emg_distance_reg;
        end
        else if (no_card_mode)
        begin
            sel_interval = uns_interval_reg;
            sel_distance = uns_distance_reg;
        end
        else
        begin
            sel_interval = def_interval_reg;
            sel_distance = def_distance_reg;
        end

        moved    = prs_pkg::mul100(in_reg.odometer - base_reg);
        dist_hit = moved >= sel_distance;
        snapped  = prs_pkg::div100(prs_pkg::mul100(base_reg) + sel_distance);

        countdown_next  = countdown_reg;
        base_next       = base_reg;
        track_int_next  = track_int_reg;
        track_rem_next  = track_rem_reg;
        track_flag_next = track_flag_reg;
        timed_take      = 1'b0;
        dist_take       = 1'b0;

        if (in_reg.op == prs_pkg::OP_TRACK)
        begin
            track_int_next = in_reg.track_interval;
            if (in_reg.track_interval != 16'd0)
            begin
                track_rem_next  = in_reg.track_validity;
                track_flag_next = 1'b1;
            end
            else
            begin
                track_flag_next = 1'b0;
            end
        end
        else
        begin
            countdown_next = cd_dec;
            if (track_flag_reg)
            begin
                track_rem_next = rem_dec;
                if (cd_dec == 32'd0)
                begin
                    timed_take     = 1'b1;
                    countdown_next = {16'd0, track_int_reg};
                end
                if (rem_dec == 32'd0)
                begin
                    track_flag_next = 1'b0;
                end
            end
            else
            begin
                unique case (policy_reg) inside
                    prs_pkg::POL_DISTANCE:
                    begin
                        countdown_next = prs_pkg::RST_COUNTDOWN;
                        dist_take      = dist_hit;
                    end
                    prs_pkg::POL_TIMED, prs_pkg::POL_BOTH:
                    begin
                        if (cd_dec == 32'd0)
                        begin
                            timed_take     = 1'b1;
                            countdown_next = sel_interval;
                        end
                        dist_take = dist_hit && (policy_reg == prs_pkg::POL_BOTH);
                    end
                    default: ;
                endcase
            end
        end

        if (dist_take)
        begin
            base_next = snapped;
        end

        out_next.report_count = {1'b0, timed_take} + {1'b0, dist_take};
        out_next.odometer_out = dist_take ? snapped : in_reg.odometer;
        out_next.tracking_on  = track_flag_next;
    end

    // scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg  <= prs_pkg::RST_COUNTDOWN;
            base_reg       <= 32'd0;
            track_int_reg  <= 16'd0;
            track_rem_reg  <= 32'd0;
            track_flag_reg <= 1'b0;
        end
        else if (advance)
        begin
            countdown_reg  <= countdown_next;
            base_reg       <= base_next;
            track_int_reg  <= track_int_next;
            track_rem_reg  <= track_rem_next;
            track_flag_reg <= track_flag_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || rsp_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: hdl/prs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_checker
// Port-level checks for the position report scheduler, bound to the top.
// ----------------------------------------------------------------------------
module prs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input prs_pkg::prs_out_t               rsp
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // a waiting item stays offered
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid)
        else $error("request withdrawn before acceptance");

    // a fresh result comes from an accepted item
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without a matching item");

    // two reports only on a tick outside tracking
    a_two_reports: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.report_count == 2'd2) |-> !rsp.tracking_on)
        else $error("double report while tracking");

    // report count never exceeds two
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !$stable(rsp) |-> rsp.report_count != 2'd3)
        else $error("report count out of range");

endmodule

bind position_report_scheduler_unit prs_checker u_prs_checker (.*);

// File: tb/sv/position_report_scheduler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_report_scheduler_unit_test
// Self-checking bench for the position report scheduler. Ticks and tracking
// commands go in over a valid/ready channel with random gaps. A scoreboard
// predicts report count, snapped mileage and tracking flag for every item.
// The timed, distance and combined policies run under several register
// settings, the extremes among them. The receiver stalls at random, and once
// holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module position_report_scheduler_unit_test;

    localparam int          CYCLE_LIMIT = 300000;
    localparam logic [1:0]  POL_UNUSED  = 2'd3;
    localparam logic [31:0] DIST_SCALE  = 32'd100;

    typedef enum logic [1:0] {SEL_NORMAL, SEL_NOCARD, SEL_SOS} state_sel_e;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_ready;
    prs_pkg::prs_in_t              req = '0;
    logic                          rsp_valid;
    logic                          rsp_ready = 1'b0;
    prs_pkg::prs_out_t             rsp;
    logic                          cfg_we = 1'b0;
    logic [prs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                   cfg_data = '0;

    // register copies
    logic [1:0]  policy_cfg;
    logic        scheme_cfg;
    logic [31:0] intv_def, intv_uns, intv_emg;
    logic [31:0] dist_def, dist_uns, dist_emg;

    // scheduler state copies
    logic [31:0] cd_left;
    logic [31:0] base_mileage;
    logic [15:0] trk_interval;
    logic [31:0] trk_left;
    logic        trk_active;

    prs_pkg::prs_out_t pending_reports[$];
    prs_pkg::prs_out_t want_rsp;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          rsp_hold_cycles = 0;
    bit          sender_paced = 1'b1;
    bit          receiver_paced = 1'b1;
    logic [31:0] odo_walk = '0;

    position_report_scheduler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic reset_model();
        policy_cfg   = prs_pkg::POL_TIMED;
        scheme_cfg   = 1'b0;
        intv_def     = prs_pkg::RST_DEF_INTERVAL;
        intv_uns     = prs_pkg::RST_UNS_INTERVAL;
        intv_emg     = prs_pkg::RST_EMG_INTERVAL;
        dist_def     = prs_pkg::RST_DEF_DISTANCE;
        dist_uns     = prs_pkg::RST_UNS_DISTANCE;
        dist_emg     = prs_pkg::RST_EMG_DISTANCE;
        cd_left      = prs_pkg::RST_COUNTDOWN;
        base_mileage = '0;
        trk_interval = '0;
        trk_left     = '0;
        trk_active   = 1'b0;
    endtask

    function automatic state_sel_e pick_state(logic sos, logic card);
        if (sos)
            return SEL_SOS;
        if (scheme_cfg && !card)
            return SEL_NOCARD;
        return SEL_NORMAL;
    endfunction

    function automatic logic [31:0] pick_by_state(state_sel_e st, logic [31:0] nrm,
                                                  logic [31:0] nocard, logic [31:0] sos);
        case (st)
            SEL_SOS:    return sos;
            SEL_NOCARD: return nocard;
            default:    return nrm;
        endcase
    endfunction

    function automatic logic [1:0] distance_step(state_sel_e st, inout logic [31:0] odo);
        logic [31:0] thr;
        logic [31:0] moved;
        logic [31:0] snapped;
        thr   = pick_by_state(st, dist_def, dist_uns, dist_emg);
        moved = (odo - base_mileage) * DIST_SCALE;
        if (moved >= thr)
        begin
            snapped      = (base_mileage * DIST_SCALE + thr) / DIST_SCALE;
            odo          = snapped;
            base_mileage = snapped;
            return 2'd1;
        end
        return 2'd0;
    endfunction

    function automatic prs_pkg::prs_out_t predict_report(prs_pkg::prs_in_t it);
        prs_pkg::prs_out_t r;
        logic [1:0]  n;
        logic [31:0] odo;
        state_sel_e  st;
        n   = 2'd0;
        odo = it.odometer;
        if (it.op == prs_pkg::OP_TRACK)
        begin
            trk_interval = it.track_interval;
            if (it.track_interval != 16'd0)
            begin
                trk_left   = it.track_validity;
                trk_active = 1'b1;
            end
            else
                trk_active = 1'b0;
        end
        else
        begin
            cd_left = cd_left - 32'd1;
            if (trk_active)
            begin
                trk_left = trk_left - 32'd1;
                if (cd_left == 32'd0)
                begin
                    n       = n + 2'd1;
                    cd_left = {16'd0, trk_interval};
                end
                if (trk_left == 32'd0)
                    trk_active = 1'b0;
            end
            else
            begin
                st = pick_state(it.sos_active, it.card_present);
                if (policy_cfg == prs_pkg::POL_DISTANCE)
                begin
                    cd_left = 32'd1;
                    n = n + distance_step(st, odo);
                end
                else if (policy_cfg == prs_pkg::POL_TIMED || policy_cfg == prs_pkg::POL_BOTH)
                begin
                    if (cd_left == 32'd0)
                    begin
                        n       = n + 2'd1;
                        cd_left = pick_by_state(st, intv_def, intv_uns, intv_emg);
                    end
                    if (policy_cfg == prs_pkg::POL_BOTH)
                        n = n + distance_step(st, odo);
                end
            end
        end
        r.report_count = n;
        r.odometer_out = odo;
        r.tracking_on  = trk_active;
        return r;
    endfunction

    function automatic prs_pkg::prs_in_t make_item(logic op, logic sos, logic card,
                                                   logic [31:0] odo, logic [15:0] tint,
                                                   logic [31:0] tval);
        prs_pkg::prs_in_t it;
        it.op             = op;
        it.sos_active     = sos;
        it.card_present   = card;
        it.odometer       = odo;
        it.track_interval = tint;
        it.track_validity = tval;
        return it;
    endfunction

    task automatic set_register(logic [prs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            prs_pkg::CFG_POLICY:       policy_cfg = val[1:0];
            prs_pkg::CFG_SCHEME:       scheme_cfg = val[0];
            prs_pkg::CFG_DEF_INTERVAL: intv_def = val;
            prs_pkg::CFG_UNS_INTERVAL: intv_uns = val;
            prs_pkg::CFG_EMG_INTERVAL: intv_emg = val;
            prs_pkg::CFG_DEF_DISTANCE: dist_def = val;
            prs_pkg::CFG_UNS_DISTANCE: dist_uns = val;
            prs_pkg::CFG_EMG_DISTANCE: dist_emg = val;
            default: ;
        endcase
    endtask

    task automatic send_item(prs_pkg::prs_in_t it);
        int gap;
        gap = sender_paced ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (!req_ready);
        pending_reports.push_back(predict_report(it));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver side
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                stall = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            else
                stall = receiver_paced ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid && rsp_hold_cycles == 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result with no item outstanding");
                mismatch_count++;
            end
            else
            begin
                want_rsp = pending_reports.pop_front();
                if (rsp.report_count !== want_rsp.report_count)
                begin
                    $error("report_count expected %0d actual %0d",
                           want_rsp.report_count, rsp.report_count);
                    mismatch_count++;
                end
                if (rsp.odometer_out !== want_rsp.odometer_out)
                begin
                    $error("odometer_out expected %h actual %h",
                           want_rsp.odometer_out, rsp.odometer_out);
                    mismatch_count++;
                end
                if (rsp.tracking_on !== want_rsp.tracking_on)
                begin
                    $error("tracking_on expected %0d actual %0d",
                           want_rsp.tracking_on, rsp.tracking_on);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic prs_pkg::prs_in_t random_item();
        int          pick;
        logic [15:0] tint;
        logic [31:0] tval;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            case ($urandom_range(0, 7))
                0, 1:    tint = 16'd0;
                2:       tint = 16'hFFFF;
                3:       tint = 16'($urandom);
                default: tint = 16'($urandom_range(1, 20));
            endcase
            case ($urandom_range(0, 7))
                0:       tval = 32'd0;
                1:       tval = $urandom;
                default: tval = $urandom_range(1, 40);
            endcase
            return make_item(prs_pkg::OP_TRACK, 1'($urandom), 1'($urandom), $urandom,
                             tint, tval);
        end
        if (pick < 9)
            odo_walk = $urandom;
        else if (pick == 9)
            odo_walk = '1;
        else
            odo_walk = odo_walk + $urandom_range(0, 25);
        return make_item(prs_pkg::OP_TICK, $urandom_range(0, 3) == 0, 1'($urandom), odo_walk,
                         16'($urandom), $urandom);
    endfunction

    function automatic logic [31:0] random_interval();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $urandom_range(0, 40);
    endfunction

    function automatic logic [31:0] random_distance();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $urandom_range(0, 3000);
    endfunction

    task automatic test_reset_defaults();
        send_item(make_item(prs_pkg::OP_TICK, 1'b0, 1'b1, 32'd0, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(make_item(prs_pkg::OP_TICK, 1'b1, 1'b0, 32'hFFFF_FFFF, 16'd0, 32'd0));
        wait_drained();
    endtask

    task automatic test_tracking();
        send_item(make_item(prs_pkg::OP_TRACK, 1'b0, 1'b1, 32'd5, 16'd2, 32'd3));
        repeat (3) send_item(make_item(prs_pkg::OP_TICK, 1'b0, 1'b1, 32'd6, 16'd0, 32'd0));
        send_item(make_item(prs_pkg::OP_TRACK, 1'b1, 1'b0, 32'd7, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(make_item(prs_pkg::OP_TICK, 1'b1, 1'b0, 32'd8, 16'd0, 32'd0));
        // zero interval stops tracking
        send_item(make_item(prs_pkg::OP_TRACK, 1'b0, 1'b0, 32'd9, 16'd0, 32'd77));
        // zero validity wraps on the first tick
        send_item(make_item(prs_pkg::OP_TRACK, 1'b0, 1'b1, 32'd9, 16'd5, 32'd0));
        send_item(make_item(prs_pkg::OP_TICK, 1'b0, 1'b1, 32'd9, 16'd0, 32'd0));
        send_item(make_item(prs_pkg::OP_TRACK, 1'b0, 1'b1, 32'd9, 16'd0, 32'd0));
        wait_drained();
    endtask

    task automatic test_distance_and_modes();
        set_register(prs_pkg::CFG_POLICY, {30'd0, prs_pkg::POL_DISTANCE});
        set_register(prs_pkg::CFG_SCHEME, 32'd1);
        set_register(prs_pkg::CFG_DEF_DISTANCE, 32'd250);
        set_register(prs_pkg::CFG_UNS_DISTANCE, 32'd500);
        set_register(prs_pkg::CFG_EMG_DISTANCE, 32'd0);
        send_item(make_item(prs_pkg::OP_TICK, 1'b0, 1'b1, 32'd2, 16'd0, 32'd0));
        send_item(make_item(prs_pkg::OP_TICK, 1'b0, 1'b1, 32'd3, 16'd0, 32'd0));
        send_item(make_item(prs_pkg::OP_TICK, 1'b0, 1'b0, 32'd8, 16'd0, 32'd0));
        send_item(make_item(prs_pkg::OP_TICK, 1'b1, 1'b0, 32'd7, 16'd0, 32'd0));
        send_item(make_item(prs_pkg::OP_TICK, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'd0, 32'd0));
        wait_drained();
        // combined policy with a zero reload
        set_register(prs_pkg::CFG_POLICY, {30'd0, prs_pkg::POL_BOTH});
        set_register(prs_pkg::CFG_DEF_INTERVAL, 32'd0);
        repeat (3) send_item(make_item(prs_pkg::OP_TICK, 1'b0, 1'b1, 32'd20, 16'd0, 32'd0));
        wait_drained();
        set_register(prs_pkg::CFG_POLICY, {30'd0, POL_UNUSED});
        repeat (2) send_item(make_item(prs_pkg::OP_TICK, 1'b0, 1'b1, 32'd40, 16'd0, 32'd0));
        wait_drained();
    endtask

    task automatic load_settings(int phase);
        logic [31:0] fill;
        if (phase < 2)
        begin
            fill = (phase == 0) ? 32'd0 : 32'hFFFF_FFFF;
            set_register(prs_pkg::CFG_POLICY, (phase == 0) ? {30'd0, prs_pkg::POL_TIMED}
                                                           : {30'd0, prs_pkg::POL_BOTH});
            set_register(prs_pkg::CFG_SCHEME, (phase == 0) ? 32'd0 : 32'd1);
            set_register(prs_pkg::CFG_DEF_INTERVAL, fill);
            set_register(prs_pkg::CFG_UNS_INTERVAL, fill);
            set_register(prs_pkg::CFG_EMG_INTERVAL, fill);
            set_register(prs_pkg::CFG_DEF_DISTANCE, fill);
            set_register(prs_pkg::CFG_UNS_DISTANCE, fill);
            set_register(prs_pkg::CFG_EMG_DISTANCE, fill);
        end
        else
        begin
            set_register(prs_pkg::CFG_POLICY, {30'd0, 2'($urandom_range(0, 2))});
            set_register(prs_pkg::CFG_SCHEME, {31'd0, 1'($urandom)});
            set_register(prs_pkg::CFG_DEF_INTERVAL, random_interval());
            set_register(prs_pkg::CFG_UNS_INTERVAL, random_interval());
            set_register(prs_pkg::CFG_EMG_INTERVAL, random_interval());
            set_register(prs_pkg::CFG_DEF_DISTANCE, random_distance());
            set_register(prs_pkg::CFG_UNS_DISTANCE, random_distance());
            set_register(prs_pkg::CFG_EMG_DISTANCE, random_distance());
        end
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++)
        begin
            load_settings(phase);
            for (int i = 0; i < 235; i++)
            begin
                if (i % 60 == 0)
                begin
                    sender_paced   = ($urandom_range(0, 2) != 0);
                    receiver_paced = ($urandom_range(0, 2) != 0);
                end
                send_item(random_item());
            end
            wait_drained();
        end
        sender_paced   = 1'b1;
        receiver_paced = 1'b1;
    endtask

    task automatic test_backpressure();
        set_register(prs_pkg::CFG_POLICY, {30'd0, prs_pkg::POL_BOTH});
        set_register(prs_pkg::CFG_DEF_DISTANCE, 32'd300);
        set_register(prs_pkg::CFG_DEF_INTERVAL, 32'd3);
        sender_paced    = 1'b0;
        rsp_hold_cycles = 200;
        repeat (40) send_item(random_item());
        sender_paced = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        reset_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_tracking();
        test_distance_and_modes();
        test_random_phases();
        test_backpressure();
        wait_drained();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
